// ===== rtl/rpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants of the route pattern tokenizer.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int TOKEN_LIMIT  = 255;
  localparam int PATTERN_SPAN = 1024;

  // token queue between scanner and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int OFFSET_W = 10;
  localparam int LENGTH_W = 8;

  // configuration register word index
  localparam logic REG_SYNTAX = 1'b0;

  typedef enum logic [1:0] {
    SYNTAX_COLON = 2'd0,
    SYNTAX_ANGLE = 2'd1,
    SYNTAX_BRACE = 2'd2,
    SYNTAX_NONE  = 2'd3
  } syntax_e;

  typedef enum logic [2:0] {
    KIND_LITERAL    = 3'd0,
    KIND_PARAM      = 3'd1,
    KIND_WILDCARD   = 3'd2,
    KIND_TRAILING   = 3'd3,
    KIND_END        = 3'd4,
    KIND_ILLEGAL    = 3'd5,
    KIND_NO_PATTERN = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_SLASH       = 3'd1,
    PH_AFTER_CLOSE = 3'd2,
    PH_PARAM_OPEN  = 3'd3,
    PH_PARAM_NAME  = 3'd4,
    PH_LITERAL     = 3'd5,
    PH_STAR        = 3'd6
  } phase_e;

  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic [OFFSET_W-1:0] offset;
    kind_e               kind;
  } token_t;

  // one or two tokens caused by one pattern byte
  typedef struct packed {
    logic   two;
    token_t tok1;
    token_t tok0;
  } entry_t;

endpackage

// ===== rtl/rpt_front.sv =====
// ----------------------------------------------------------------------------
// rpt_front
// Pattern scanner: takes one byte per beat, tracks the segment phase and
// pushes the tokens each byte produces into the token queue.
// ----------------------------------------------------------------------------
module rpt_front #(
  parameter int TokenLimit  = rpt_pkg::TOKEN_LIMIT,
  parameter int PatternSpan = rpt_pkg::PATTERN_SPAN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_i,
  input  logic             begin_i,
  input  rpt_pkg::syntax_e syntax_i,
  input  logic             full_i,
  output logic             push_o,
  output rpt_pkg::entry_t  entry_o
);

  localparam int PW = $clog2(PatternSpan + 1);
  localparam int OW = $clog2(PatternSpan);
  localparam int SW = $clog2(TokenLimit + 2);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChLbr   = 8'h7B;
  localparam logic [7:0] ChRbr   = 8'h7D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == ChUnder;
  endfunction

  function automatic logic literal_bad(input logic [7:0] b);
    return b == ChStar || b == ChHash || b == ChQuest || b <= ChSpace || b == ChDel;
  endfunction

  function automatic rpt_pkg::token_t mk_tok(input rpt_pkg::kind_e kind,
                                             input logic [OW-1:0] off,
                                             input logic [SW-1:0] len);
    rpt_pkg::token_t t;
    t.kind   = kind;
    t.offset = rpt_pkg::OFFSET_W'(off);
    t.length = rpt_pkg::LENGTH_W'(len);
    return t;
  endfunction

  function automatic rpt_pkg::token_t bare_tok(input rpt_pkg::kind_e kind);
    rpt_pkg::token_t t;
    t        = '0;
    t.kind   = kind;
    return t;
  endfunction

  rpt_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [OW-1:0]   origin_q, origin_d;
  logic [SW-1:0]   size_q, size_d;
  logic            swf_q, swf_d;

  logic            accept;
  logic            opens, closes, over;
  logic            do_begin, do_close;
  rpt_pkg::kind_e  close_kind;
  logic [1:0]      n;
  rpt_pkg::entry_t ent;
  logic [OW-1:0]   pos_cur;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_cur    = OW'(pos_q);
  assign over       = size_q > SW'(TokenLimit);

  assign opens  = (byte_i == ChColon && syntax_i == rpt_pkg::SYNTAX_COLON) ||
                  (byte_i == ChLt    && syntax_i == rpt_pkg::SYNTAX_ANGLE) ||
                  (byte_i == ChLbr   && syntax_i == rpt_pkg::SYNTAX_BRACE);
  assign closes = (byte_i == ChGt  && syntax_i == rpt_pkg::SYNTAX_ANGLE) ||
                  (byte_i == ChRbr && syntax_i == rpt_pkg::SYNTAX_BRACE);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    origin_d   = origin_q;
    size_d     = size_q;
    swf_d      = swf_q;
    ent        = '0;
    n          = 2'd0;
    do_begin   = 1'b0;
    do_close   = 1'b0;
    close_kind = rpt_pkg::KIND_LITERAL;

    if (begin_i) begin
      pos_d    = PW'(1);
      origin_d = '0;
      size_d   = '0;
      if (byte_i == ChSlash) begin
        phase_d = rpt_pkg::PH_SLASH;
        swf_d   = 1'b1;
      end else begin
        phase_d  = rpt_pkg::PH_IDLE;
        swf_d    = 1'b0;
        ent.tok0 = bare_tok(rpt_pkg::KIND_NO_PATTERN);
        n        = 2'd1;
      end
    end else if (phase_q == rpt_pkg::PH_IDLE) begin
      n = 2'd0;
    end else if (pos_q >= PW'(PatternSpan)) begin
      phase_d  = rpt_pkg::PH_IDLE;
      ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
      n        = 2'd1;
    end else begin
      pos_d = pos_q + PW'(1);
      unique case (phase_q)
        rpt_pkg::PH_SLASH: begin
          if (byte_i == ChNul) begin
            phase_d = rpt_pkg::PH_IDLE;
            if (!swf_q) begin
              ent.tok0 = bare_tok(rpt_pkg::KIND_TRAILING);
              ent.tok1 = bare_tok(rpt_pkg::KIND_END);
              n        = 2'd2;
            end else begin
              ent.tok0 = bare_tok(rpt_pkg::KIND_END);
              n        = 2'd1;
            end
          end else if (byte_i == ChSlash) begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
            n        = 2'd1;
          end else begin
            do_begin = 1'b1;
          end
        end
        rpt_pkg::PH_AFTER_CLOSE: begin
          if (byte_i == ChNul) begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_END);
            n        = 2'd1;
          end else if (byte_i == ChSlash) begin
            phase_d = rpt_pkg::PH_SLASH;
            swf_d   = 1'b0;
          end else begin
            do_begin = 1'b1;
          end
        end
        rpt_pkg::PH_PARAM_OPEN: begin
          if (is_letter(byte_i)) begin
            origin_d = pos_cur;
            size_d   = SW'(1);
            phase_d  = rpt_pkg::PH_PARAM_NAME;
          end else begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
            n        = 2'd1;
          end
        end
        rpt_pkg::PH_PARAM_NAME: begin
          if (byte_i == ChNul || byte_i == ChSlash) begin
            do_close   = 1'b1;
            close_kind = rpt_pkg::KIND_PARAM;
          end else if (closes) begin
            n = 2'd1;
            if (over) begin
              phase_d  = rpt_pkg::PH_IDLE;
              ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
            end else begin
              phase_d  = rpt_pkg::PH_AFTER_CLOSE;
              ent.tok0 = mk_tok(rpt_pkg::KIND_PARAM, origin_q, size_q);
            end
          end else if (is_name_char(byte_i)) begin
            if (!over) size_d = size_q + SW'(1);
          end else begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
            n        = 2'd1;
          end
        end
        rpt_pkg::PH_LITERAL: begin
          if (byte_i == ChNul || byte_i == ChSlash) begin
            do_close   = 1'b1;
            close_kind = rpt_pkg::KIND_LITERAL;
          end else if (literal_bad(byte_i)) begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
            n        = 2'd1;
          end else if (!over) begin
            size_d = size_q + SW'(1);
          end
        end
        rpt_pkg::PH_STAR: begin
          if (byte_i == ChNul) begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_WILDCARD);
            ent.tok1 = bare_tok(rpt_pkg::KIND_END);
            n        = 2'd2;
          end else if (byte_i == ChSlash) begin
            phase_d  = rpt_pkg::PH_SLASH;
            swf_d    = 1'b0;
            ent.tok0 = bare_tok(rpt_pkg::KIND_WILDCARD);
            n        = 2'd1;
          end else begin
            phase_d  = rpt_pkg::PH_IDLE;
            ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
            n        = 2'd1;
          end
        end
        default: begin
          phase_d = rpt_pkg::PH_IDLE;
        end
      endcase

      // start a new segment on a byte that is neither NUL nor slash
      if (do_begin) begin
        swf_d = 1'b0;
        if (opens) begin
          phase_d = rpt_pkg::PH_PARAM_OPEN;
        end else if (byte_i == ChStar) begin
          phase_d = rpt_pkg::PH_STAR;
        end else if (literal_bad(byte_i)) begin
          phase_d  = rpt_pkg::PH_IDLE;
          ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
          n        = 2'd1;
        end else begin
          origin_d = pos_cur;
          size_d   = SW'(1);
          phase_d  = rpt_pkg::PH_LITERAL;
        end
      end

      // close a literal or name on NUL or slash
      if (do_close) begin
        if (over) begin
          phase_d  = rpt_pkg::PH_IDLE;
          ent.tok0 = bare_tok(rpt_pkg::KIND_ILLEGAL);
          n        = 2'd1;
        end else if (byte_i == ChNul) begin
          phase_d  = rpt_pkg::PH_IDLE;
          ent.tok0 = mk_tok(close_kind, origin_q, size_q);
          ent.tok1 = bare_tok(rpt_pkg::KIND_END);
          n        = 2'd2;
        end else begin
          phase_d  = rpt_pkg::PH_SLASH;
          swf_d    = 1'b0;
          ent.tok0 = mk_tok(close_kind, origin_q, size_q);
          n        = 2'd1;
        end
      end
    end

    ent.two = (n == 2'd2);
  end

  assign push_o  = accept && (n != 2'd0);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rpt_pkg::PH_IDLE;
      pos_q    <= '0;
      origin_q <= '0;
      size_q   <= '0;
      swf_q    <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      origin_q <= origin_d;
      size_q   <= size_d;
      swf_q    <= swf_d;
    end
  end

  // a pending token never grows past the saturation point
  a_size_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SW'(TokenLimit + 1))
    else $error("token size beyond saturation");

  // the position never runs past the span limit; once there it stays there
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(PatternSpan))
    else $error("byte position out of range");

endmodule

// ===== rtl/rpt_queue.sv =====
// ----------------------------------------------------------------------------
// rpt_queue
// Short token queue between scanner and output stage.
// ----------------------------------------------------------------------------
module rpt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rpt_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rpt_pkg::entry_t entry_o
);

  rpt_pkg::entry_t                mem_q [rpt_pkg::QUEUE_DEPTH];
  logic [rpt_pkg::QUEUE_AW-1:0]   wr_q, rd_q;
  logic [rpt_pkg::QUEUE_CW-1:0]   count_q;

  assign full_o  = count_q == rpt_pkg::QUEUE_CW'(rpt_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + rpt_pkg::QUEUE_AW'(1);
      if (pop_i)  rd_q <= rd_q + rpt_pkg::QUEUE_AW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + rpt_pkg::QUEUE_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - rpt_pkg::QUEUE_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full token queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty token queue");

endmodule

// ===== rtl/rpt_back.sv =====
// ----------------------------------------------------------------------------
// rpt_back
// Output stage: unpacks queued entries into single token beats and marks
// the last token of each byte.
// ----------------------------------------------------------------------------
module rpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  rpt_pkg::entry_t q_entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rpt_pkg::token_t token_o,
  output logic            last_o
);

  logic            valid_q;
  logic            idx_q;
  rpt_pkg::entry_t ent_q;
  logic            adv, load;

  assign last_o      = !ent_q.two || idx_q;
  assign adv         = valid_q && out_ready_i;
  assign load        = !valid_q || (adv && last_o);
  assign pop_o       = load && q_valid_i;
  assign out_valid_o = valid_q;
  assign token_o     = idx_q ? ent_q.tok1 : ent_q.tok0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load) begin
      valid_q <= q_valid_i;
      idx_q   <= 1'b0;
    end else if (adv) begin
      // move on to the second token of the entry
      idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= q_entry_i;
    end
  end

  a_second_only_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && idx_q) |-> ent_q.two)
    else $error("second beat of a single-token entry");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !last_o) |=> (valid_q && idx_q))
    else $error("second token of a pair was skipped");

endmodule

// ===== rtl/route_pattern_tokenizer.sv =====
// ----------------------------------------------------------------------------
// route_pattern_tokenizer
// Splits a byte stream of URL route patterns into tokens.
// ----------------------------------------------------------------------------
// The block takes one pattern byte per clock cycle. A byte gives zero, one or
// two tokens; each token is one output beat, and a terminating NUL that closes
// a pending segment gives two beats. A four-entry token queue between the
// scanner and the output register absorbs these pairs and output stalls;
// input is held off only while that queue is full. Each token is written into
// the queue first and then loaded into the output register.
// Register parameter_syntax (offset 0x0) selects the parameter marker and is
// to be written only while no pattern is in flight.
module route_pattern_tokenizer #(
  parameter int TokenLimit  = rpt_pkg::TOKEN_LIMIT,
  parameter int PatternSpan = rpt_pkg::PATTERN_SPAN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pattern_byte
  input  logic        s_axis_tuser,   // [0] pattern_begin
  // token stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] token_kind, [12:3] token_offset,
                                      // [20:13] token_length, [23:21] zero
  output logic        m_axis_tlast,   // run_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rpt_pkg::syntax_e syntax_q;
  logic             cfg_wr;

  logic             push;
  logic             full;
  rpt_pkg::entry_t  push_entry;
  logic             pop;
  logic             q_valid;
  rpt_pkg::entry_t  q_entry;
  rpt_pkg::token_t  tok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rpt_pkg::REG_SYNTAX);
  assign prdata = (paddr[2] == rpt_pkg::REG_SYNTAX) ? {30'd0, syntax_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syntax_q <= rpt_pkg::SYNTAX_COLON;
    end else if (cfg_wr) begin
      syntax_q <= rpt_pkg::syntax_e'(pwdata[1:0]);
    end
  end

  rpt_front #(
    .TokenLimit  (TokenLimit),
    .PatternSpan (PatternSpan)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .begin_i    (s_axis_tuser),
    .syntax_i   (syntax_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  rpt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  rpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .token_o     (tok),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, tok.length, tok.offset, tok.kind};

endmodule
